// File: hw/rtl/kms_pkg.sv
// Shared constants for the keyed move statistics table.
package kms_pkg;

    localparam int MEAN_W = 26;
    localparam int CNT_W  = 16;
    localparam int GAP_W  = 10;
    localparam int FRAC_W = 16;
    localparam int NUM_W  = MEAN_W + CNT_W;
    localparam int DEN_W  = CNT_W + 1;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 64;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [1:0] ACT_RECORD = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_BEST   = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BOARD_FULL = 2'd1;
    localparam logic [1:0] ST_MOVE_FULL  = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd3;

endpackage

// File: hw/rtl/keyed_move_statistics_table_core.sv
// Top level of the keyed move statistics table: sequencer, tables and result register.
//
// Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser; s_tuser carries the
// action (record, lookup, best). Result words leave on m_tvalid/m_tready/m_tdata/m_tuser,
// one result word per input word, with found and status in m_tuser.
// A word is accepted only while the sequencer is idle. The board table is searched
// linearly, each stored board in a read state and a compare state, then the board's
// moves in the same way, through single-port memories with registered reads.
// A record then passes the multiplier and the serial divider that forms the new mean.
// Reset empties both tables at once through the board count; no clearing pass runs.
// A finished result is held in the output register until taken. While the
// receiver stalls, the next word may already be accepted and processed; it waits
// for the output register to drain before its result is loaded.
module keyed_move_statistics_table_core #(
    parameter int KEY_BITS   = 64,
    parameter int MAX_BOARDS = 64,
    parameter int MAX_MOVES  = 32,
    parameter int COORD_BITS = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // board_key, from_x, from_y, to_x, to_y, gap, min_count, zero pad
    input  logic [kms_pkg::IN_DATA_W-1:0]  s_tdata,
    // action
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // best_from_x, best_from_y, best_to_x, best_to_y, mean_gap, sample_count, zero pad
    output logic [kms_pkg::OUT_DATA_W-1:0] m_tdata,
    // found, status
    output logic [2:0]                     m_tuser
);
    import kms_pkg::*;

    localparam int CB      = (COORD_BITS < 4) ? COORD_BITS : 4;
    localparam int CODE_W  = 4 * CB;
    localparam int ENT_W   = CODE_W + MEAN_W + CNT_W;
    localparam int MV_DEP  = MAX_BOARDS * MAX_MOVES;
    localparam int BU_W    = $clog2(MAX_BOARDS + 1);
    localparam int BA_W    = (MAX_BOARDS > 1) ? $clog2(MAX_BOARDS) : 1;
    localparam int MU_W    = $clog2(MAX_MOVES + 1);
    localparam int BASE_W  = $clog2(MV_DEP + 1);
    localparam int MA_W    = (MV_DEP > 1) ? $clog2(MV_DEP) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_BRD, S_BCMP, S_MRD, S_MCMP, S_MUL, S_DIVGO, S_DIVWAIT, S_OUT
    } state_t;

    logic [KEY_BITS-1:0] board_keys [MAX_BOARDS];
    logic [MU_W-1:0]     moves_used [MAX_BOARDS];
    logic [ENT_W-1:0]    move_tab   [MV_DEP];

    state_t              state_reg;
    logic [1:0]          act_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [GAP_W-1:0]    gap_reg;
    logic [CNT_W-1:0]    minc_reg;
    logic [BU_W-1:0]     boards_used_reg;
    logic [BU_W-1:0]     bi_reg;
    logic [BASE_W-1:0]   base_reg;
    logic [MU_W-1:0]     nmoves_reg;
    logic [MU_W-1:0]     mi_reg;
    logic [MA_W-1:0]     slot_reg;
    logic                have_best_reg;
    logic [ENT_W-1:0]    best_reg;
    logic [MEAN_W-1:0]   cur_mean_reg;
    logic [CNT_W-1:0]    cur_cnt_reg;
    logic [NUM_W-1:0]    num_reg;
    logic                res_found_reg;
    logic [1:0]          res_status_reg;
    logic [ENT_W-1:0]    res_ent_reg;
    logic                m_tvalid_reg;
    logic [2:0]          m_tuser_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic [KEY_BITS-1:0] bk_rd_reg;
    logic [MU_W-1:0]     mu_rd_reg;
    logic [ENT_W-1:0]    mv_rd_reg;

    logic [BASE_W-1:0]   slot_sum;
    logic [MA_W-1:0]     mv_raddr;
    logic [BA_W-1:0]     b_addr;
    logic                bk_we;
    logic                mu_we;
    logic [MU_W-1:0]     mu_wdata;
    logic                mv_we;
    logic [ENT_W-1:0]    mv_wdata;
    logic                div_start;
    logic                div_done;
    logic [NUM_W-1:0]    div_quot;
    logic [CNT_W-1:0]    new_cnt;
    logic [CODE_W-1:0]   in_code;
    logic [CODE_W-1:0]   ent_code;
    logic [MEAN_W-1:0]   ent_mean;
    logic [CNT_W-1:0]    ent_cnt;
    logic                out_free;

    assign in_code = {s_tdata[64 +: CB], s_tdata[68 +: CB], s_tdata[72 +: CB], s_tdata[76 +: CB]};
    assign slot_sum = base_reg + BASE_W'(mi_reg);
    assign mv_raddr = slot_sum[MA_W-1:0];
    assign b_addr   = bi_reg[BA_W-1:0];
    assign ent_code = mv_rd_reg[ENT_W-1 -: CODE_W];
    assign ent_mean = mv_rd_reg[CNT_W +: MEAN_W];
    assign ent_cnt  = mv_rd_reg[CNT_W-1:0];
    assign new_cnt  = (cur_cnt_reg == CNT_MAX) ? cur_cnt_reg : cur_cnt_reg + 1'b1;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        bk_we     = 1'b0;
        mu_we     = 1'b0;
        mu_wdata  = '0;
        mv_we     = 1'b0;
        mv_wdata  = {code_reg, div_quot[MEAN_W-1:0], new_cnt};
        div_start = (state_reg == S_DIVGO);
        case (state_reg)
            S_BRD:
            begin
                if (bi_reg == boards_used_reg && act_reg == ACT_RECORD &&
                    boards_used_reg != BU_W'(MAX_BOARDS))
                begin
                    bk_we = 1'b1;
                    mu_we = 1'b1;
                end
            end
            S_MRD:
            begin
                if (mi_reg == nmoves_reg && act_reg == ACT_RECORD &&
                    nmoves_reg != MU_W'(MAX_MOVES))
                begin
                    mu_we    = 1'b1;
                    mu_wdata = nmoves_reg + 1'b1;
                end
            end
            S_DIVWAIT:
            begin
                mv_we = div_done;
            end
            default:
            begin
                bk_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (bk_we)
            board_keys[b_addr] <= key_reg;
        bk_rd_reg <= board_keys[b_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mu_we)
            moves_used[b_addr] <= mu_wdata;
        mu_rd_reg <= moves_used[b_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mv_we)
            move_tab[slot_reg] <= mv_wdata;
        mv_rd_reg <= move_tab[mv_raddr];
    end

    kms_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   ({1'b0, cur_cnt_reg} + DEN_W'(1)),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            boards_used_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && state_reg != S_OUT)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        act_reg        <= s_tuser;
                        key_reg        <= s_tdata[KEY_BITS-1:0];
                        code_reg       <= in_code;
                        gap_reg        <= s_tdata[80 +: GAP_W];
                        minc_reg       <= s_tdata[90 +: CNT_W];
                        bi_reg         <= '0;
                        base_reg       <= '0;
                        res_found_reg  <= 1'b0;
                        res_status_reg <= ST_NOT_FOUND;
                        res_ent_reg    <= '0;
                        if (s_tuser == ACT_RECORD || s_tuser == ACT_LOOKUP ||
                            s_tuser == ACT_BEST)
                            state_reg <= S_BRD;
                        else
                            state_reg <= S_OUT;
                    end
                end
                S_BRD:
                begin
                    if (bi_reg == boards_used_reg)
                    begin
                        if (act_reg != ACT_RECORD)
                            state_reg <= S_OUT;
                        else if (boards_used_reg == BU_W'(MAX_BOARDS))
                        begin
                            res_status_reg <= ST_BOARD_FULL;
                            state_reg      <= S_OUT;
                        end
                        else
                        begin
                            boards_used_reg <= boards_used_reg + 1'b1;
                            nmoves_reg      <= '0;
                            mi_reg          <= '0;
                            have_best_reg   <= 1'b0;
                            state_reg       <= S_MRD;
                        end
                    end
                    else
                        state_reg <= S_BCMP;
                end
                S_BCMP:
                begin
                    if (bk_rd_reg == key_reg)
                    begin
                        nmoves_reg    <= mu_rd_reg;
                        mi_reg        <= '0;
                        have_best_reg <= 1'b0;
                        state_reg     <= S_MRD;
                    end
                    else
                    begin
                        bi_reg    <= bi_reg + 1'b1;
                        base_reg  <= base_reg + BASE_W'(MAX_MOVES);
                        state_reg <= S_BRD;
                    end
                end
                S_MRD:
                begin
                    slot_reg <= mv_raddr;
                    if (mi_reg == nmoves_reg)
                    begin
                        if (act_reg == ACT_BEST && have_best_reg)
                        begin
                            res_found_reg  <= 1'b1;
                            res_status_reg <= ST_OK;
                            res_ent_reg    <= best_reg;
                            state_reg      <= S_OUT;
                        end
                        else if (act_reg == ACT_RECORD && nmoves_reg != MU_W'(MAX_MOVES))
                        begin
                            cur_mean_reg <= '0;
                            cur_cnt_reg  <= '0;
                            state_reg    <= S_MUL;
                        end
                        else
                        begin
                            if (act_reg == ACT_RECORD)
                                res_status_reg <= ST_MOVE_FULL;
                            state_reg <= S_OUT;
                        end
                    end
                    else
                        state_reg <= S_MCMP;
                end
                S_MCMP:
                begin
                    mi_reg <= mi_reg + 1'b1;
                    if (act_reg == ACT_BEST)
                    begin
                        state_reg <= S_MRD;
                        if (ent_cnt >= minc_reg &&
                            (!have_best_reg || ent_mean > best_reg[CNT_W +: MEAN_W]))
                        begin
                            have_best_reg <= 1'b1;
                            best_reg      <= mv_rd_reg;
                        end
                    end
                    else if (ent_code == code_reg)
                    begin
                        if (act_reg == ACT_LOOKUP)
                        begin
                            res_found_reg  <= 1'b1;
                            res_status_reg <= ST_OK;
                            res_ent_reg    <= mv_rd_reg;
                            state_reg      <= S_OUT;
                        end
                        else
                        begin
                            cur_mean_reg <= ent_mean;
                            cur_cnt_reg  <= ent_cnt;
                            state_reg    <= S_MUL;
                        end
                    end
                    else
                        state_reg <= S_MRD;
                end
                S_MUL:
                begin
                    num_reg   <= cur_mean_reg * cur_cnt_reg +
                                 (NUM_W'(gap_reg) << FRAC_W);
                    state_reg <= S_DIVGO;
                end
                S_DIVGO:
                begin
                    state_reg <= S_DIVWAIT;
                end
                S_DIVWAIT:
                begin
                    if (div_done)
                    begin
                        res_found_reg  <= 1'b1;
                        res_status_reg <= ST_OK;
                        res_ent_reg    <= mv_wdata;
                        state_reg      <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= {res_status_reg, res_found_reg};
                        m_tdata_reg  <= {
                            6'd0,
                            res_ent_reg[CNT_W-1:0],
                            res_ent_reg[CNT_W +: MEAN_W],
                            4'(res_ent_reg[ENT_W-4*CB +: CB]),
                            4'(res_ent_reg[ENT_W-3*CB +: CB]),
                            4'(res_ent_reg[ENT_W-2*CB +: CB]),
                            4'(res_ent_reg[ENT_W-CB +: CB])
                        };
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: hw/rtl/kms_div.sv
// Restoring serial divider, one quotient bit per cycle.
module kms_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [kms_pkg::NUM_W-1:0] num,
    input  logic [kms_pkg::DEN_W-1:0] den,
    output logic                      done,
    output logic [kms_pkg::NUM_W-1:0] quot
);
    import kms_pkg::*;

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  q_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W:0]    shifted;
    logic [DEN_W+1:0]  diff;

    assign shifted = {rem_reg, q_reg[NUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[DEN_W+1])
            begin
                rem_reg <= diff[DEN_W-1:0];
                q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DEN_W-1:0];
                q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the keyed move statistics table core.
module testbench;
    import kms_pkg::*;

    localparam int N_BOARDS = 64;
    localparam int N_MOVES  = 32;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic             found;
        logic [1:0]       status;
        logic [15:0]      code;
        logic [MEAN_W-1:0] mean;
        logic [CNT_W-1:0] count;
    } move_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [2:0]            m_tuser;

    logic [63:0]       table_keys [N_BOARDS];
    int                table_boards;
    int                table_moves [N_BOARDS];
    logic [15:0]       table_code [N_BOARDS*N_MOVES];
    logic [MEAN_W-1:0] table_mean [N_BOARDS*N_MOVES];
    logic [CNT_W-1:0]  table_count [N_BOARDS*N_MOVES];

    move_result_t pending_results [$];
    int  mismatches;
    int  results_seen;
    int  words_sent;
    int  idle_cycles;
    bit  no_idle;

    keyed_move_statistics_table_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int locate_board(logic [63:0] key);
        for (int i = 0; i < table_boards; i++)
            if (table_keys[i] == key)
                return i;
        return -1;
    endfunction

    function automatic int locate_move(int b, logic [15:0] code);
        for (int i = 0; i < table_moves[b]; i++)
            if (table_code[b*N_MOVES+i] == code)
                return i;
        return -1;
    endfunction

    function automatic move_result_t update_table(logic [1:0] act, logic [63:0] key,
                                                  logic [15:0] code, logic [9:0] gap,
                                                  logic [15:0] minc);
        move_result_t r;
        int b;
        int mv;
        int slot;
        int best;
        logic [63:0] num;
        logic [63:0] quo;
        r = '0;
        r.status = ST_NOT_FOUND;
        b = locate_board(key);
        if (act == ACT_RECORD)
        begin
            if (b < 0)
            begin
                if (table_boards >= N_BOARDS)
                begin
                    r.status = ST_BOARD_FULL;
                    return r;
                end
                b = table_boards;
                table_keys[b] = key;
                table_moves[b] = 0;
                table_boards++;
            end
            mv = locate_move(b, code);
            if (mv < 0)
            begin
                if (table_moves[b] >= N_MOVES)
                begin
                    r.status = ST_MOVE_FULL;
                    return r;
                end
                mv = table_moves[b];
                slot = b*N_MOVES + mv;
                table_code[slot] = code;
                table_mean[slot] = '0;
                table_count[slot] = '0;
                table_moves[b]++;
            end
            slot = b*N_MOVES + mv;
            num = 64'(table_mean[slot]) * 64'(table_count[slot]) + (64'(gap) << FRAC_W);
            quo = num / (64'(table_count[slot]) + 64'd1);
            table_mean[slot] = quo[MEAN_W-1:0];
            if (table_count[slot] != CNT_MAX)
                table_count[slot] = table_count[slot] + 1'b1;
            r = '{1'b1, ST_OK, code, table_mean[slot], table_count[slot]};
        end
        else if (act == ACT_LOOKUP)
        begin
            if (b >= 0)
            begin
                mv = locate_move(b, code);
                if (mv >= 0)
                begin
                    slot = b*N_MOVES + mv;
                    r = '{1'b1, ST_OK, code, table_mean[slot], table_count[slot]};
                end
            end
        end
        else if (act == ACT_BEST && b >= 0)
        begin
            best = -1;
            for (int i = 0; i < table_moves[b]; i++)
            begin
                slot = b*N_MOVES + i;
                if (table_count[slot] >= minc &&
                    (best < 0 || table_mean[slot] > table_mean[b*N_MOVES+best]))
                    best = i;
            end
            if (best >= 0)
            begin
                slot = b*N_MOVES + best;
                r = '{1'b1, ST_OK, table_code[slot], table_mean[slot], table_count[slot]};
            end
        end
        return r;
    endfunction

    task automatic send_word(logic [1:0] act, logic [63:0] key, logic [15:0] code,
                             logic [9:0] gap, logic [15:0] minc);
        int gap_cycles;
        gap_cycles = no_idle ? 0 : $urandom_range(0, 9);
        if (gap_cycles > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap_cycles) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'd0, minc, gap, code[3:0], code[7:4], code[11:8], code[15:12], key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(update_table(act, key, code, gap, minc));
        words_sent++;
    endtask

    task automatic test_empty_table();
        send_word(ACT_LOOKUP, 64'h0, 16'h0000, 10'd0, 16'd0);
        send_word(ACT_BEST, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 10'd1023, 16'd0);
        send_word(2'd3, 64'h1234_5678_9ABC_DEF0, 16'h1234, 10'd5, 16'hFFFF);
    endtask

    task automatic test_record_extremes();
        send_word(ACT_RECORD, 64'h0, 16'h0000, 10'd0, 16'd0);
        send_word(ACT_RECORD, 64'h0, 16'hFFFF, 10'd1023, 16'hFFFF);
        send_word(ACT_RECORD, 64'h0, 16'hFFFF, 10'd1023, 16'd0);
        send_word(ACT_RECORD, 64'h0, 16'hFFFF, 10'd0, 16'd0);
        send_word(ACT_LOOKUP, 64'h0, 16'hFFFF, 10'd0, 16'd0);
        send_word(ACT_LOOKUP, 64'h0, 16'h0F0F, 10'd0, 16'd0);
        send_word(ACT_BEST, 64'h0, 16'h0, 10'd0, 16'd0);
        send_word(ACT_BEST, 64'h0, 16'h0, 10'd0, 16'd3);
        send_word(ACT_BEST, 64'h0, 16'h0, 10'd0, 16'hFFFF);
    endtask

    task automatic test_move_table_full();
        logic [63:0] key;
        key = 64'hFFFF_FFFF_FFFF_FFFF;
        for (int i = 0; i < N_MOVES; i++)
            send_word(ACT_RECORD, key, 16'(i * 16'h0841), 10'd512, 16'd0);
        send_word(ACT_BEST, key, 16'h0, 10'd0, 16'd0);
        send_word(ACT_RECORD, key, 16'hABCD, 10'd7, 16'd0);
        send_word(ACT_LOOKUP, key, 16'hABCD, 10'd0, 16'd0);
    endtask

    task automatic test_board_table_full();
        while (table_boards < N_BOARDS)
            send_word(ACT_RECORD, {$urandom, $urandom}, 16'($urandom),
                      10'($urandom), 16'($urandom));
        send_word(ACT_RECORD, 64'h5555_AAAA_5555_AAAA, 16'h0001, 10'd3, 16'd0);
        send_word(ACT_LOOKUP, 64'h5555_AAAA_5555_AAAA, 16'h0001, 10'd0, 16'd0);
    endtask

    task automatic test_random_traffic(int count);
        logic [63:0] key;
        logic [15:0] code;
        logic [1:0]  act;
        logic [15:0] minc;
        int b;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            if (n % 150 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            b = $urandom_range(0, N_BOARDS - 1);
            key = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : table_keys[b];
            if ($urandom_range(0, 9) < 7 && table_moves[b] > 0)
                code = table_code[b*N_MOVES + $urandom_range(0, table_moves[b] - 1)];
            else
                code = 16'($urandom);
            pick = $urandom_range(0, 19);
            act = (pick < 10) ? ACT_RECORD : (pick < 15) ? ACT_LOOKUP :
                  (pick < 19) ? ACT_BEST : 2'd3;
            minc = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
            send_word(act, key, code, 10'($urandom), minc);
        end
    endtask

    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            move_result_t got;
            move_result_t want;
            got = '{m_tuser[0], m_tuser[2:1],
                    {m_tdata[3:0], m_tdata[7:4], m_tdata[11:8], m_tdata[15:12]},
                    m_tdata[41:16], m_tdata[57:42]};
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word: %p", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, actual %p", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d results outstanding.",
                     pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        mismatches = 0;
        results_seen = 0;
        words_sent = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        table_boards = 0;
        foreach (table_moves[i])
            table_moves[i] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_record_extremes();
        test_move_table_full();
        test_board_table_full();
        test_random_traffic(840);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("Sent %0d words covering record, lookup, best and unused actions,", words_sent);
        $display("full board and move tables; %0d results compared.", results_seen);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
